[hw/rtl/sik_pkg.sv]
// shared constants, widths and the arctangent table for the swerve kinematics block
// no dependencies; imported by sik_wheel and swerve_inverse_kinematics
package sik_pkg;

	// rotation count, capped by the table length
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int NSTEP        = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	// datapath widths
	localparam int VW   = 29;   // wheel velocity, um/s, signed
	localparam int FRAC = 24;   // cordic input scaling
	localparam int CW   = 56;   // cordic x/y, signed
	localparam int ZW   = 24;   // angle accumulator, 1/25600 deg, signed
	localparam int SQW  = 58;   // sum of squares
	localparam int MAGW = 29;   // magnitude
	localparam int PRW  = 45;   // magnitude times rpm factor
	localparam int NW   = 46;   // product plus rounding offset
	localparam int QW   = 20;   // speed

	// divide by 16000000 = 2^10 * 15625 as a shift and a reciprocal multiply
	localparam int DIV_SH = 10;         // power-of-two part of the divisor
	localparam int NQW    = 34;         // rounded product after the shift
	localparam int NQH    = 17;         // split point of the reciprocal multiply
	localparam int PPW    = NQW + NQH;  // one partial product
	localparam int PSW    = 2 * NQW;    // full reciprocal product
	localparam int RCP_SH = 47;         // reciprocal scaling
	localparam logic [NQW-1:0] RCP_MUL = 34'd9007199255;  // ceil(2^47 / 15625)

	// wheel latency: squares, sum, root bits, product, rounding, two reciprocal stages
	localparam int MAG_LAT = 6 + MAGW;
	localparam int ANG_DLY = MAG_LAT - NSTEP - 2;

	localparam logic signed [ZW-1:0] Z_QUARTER = 24'sd2304000;
	localparam logic signed [ZW-1:0] Z_ROUND   = 24'sd128;
	localparam logic signed [ZW-1:0] Z_LIMIT   = 24'sd18000;
	localparam logic [NW-1:0]        ROUND_HALF = 46'd8000000;
	localparam logic [NW-1:0]        SAT_LIMIT  = 46'd16777216000000;
	localparam logic [QW-1:0]        SPEED_MAX  = 20'hFFFFF;

	typedef enum logic [1:0] {
		REG_CAL_REQ  = 2'd0,
		REG_HALF_LEN = 2'd1,
		REG_HALF_WID = 2'd2,
		REG_RPM      = 2'd3
	} reg_idx_t;

	typedef logic signed [VW-1:0] wvel_t;

	// atan(2^-i) in 1/25600 deg, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 24'sd1152000;
			1:  r = 24'sd680065;
			2:  r = 24'sd359328;
			3:  r = 24'sd182400;
			4:  r = 24'sd91554;
			5:  r = 24'sd45822;
			6:  r = 24'sd22916;
			7:  r = 24'sd11459;
			8:  r = 24'sd5730;
			9:  r = 24'sd2865;
			10: r = 24'sd1432;
			11: r = 24'sd716;
			12: r = 24'sd358;
			13: r = 24'sd179;
			14: r = 24'sd90;
			15: r = 24'sd45;
			16: r = 24'sd22;
			17: r = 24'sd11;
			18: r = 24'sd6;
			19: r = 24'sd3;
			20: r = 24'sd1;
			21: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/sik_wheel.sv]
// one wheel: pipelined cordic steer angle and pipelined magnitude / speed path
// depends on sik_pkg
module sik_wheel import sik_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  wvel_t           vx,
	input  wvel_t           vy,
	input  logic [15:0]     meas,
	input  logic [15:0]     rpm,
	output logic [15:0]     angle,
	output logic [QW-1:0]   speed
);

	// ---------------- angle path ----------------
	logic signed [CW-1:0] xs, ys, px, py;
	logic signed [ZW-1:0] pz;

	assign xs = {{(CW-VW-FRAC){vx[VW-1]}}, vx, {FRAC{1'b0}}};
	assign ys = {{(CW-VW-FRAC){vy[VW-1]}}, vy, {FRAC{1'b0}}};

	// fold left half plane into the right one
	always_comb begin
		if (xs < 0) begin
			if (ys >= 0) begin
				px = ys;
				py = -xs;
				pz = Z_QUARTER;
			end else begin
				px = -ys;
				py = xs;
				pz = -Z_QUARTER;
			end
		end else begin
			px = xs;
			py = ys;
			pz = '0;
		end
	end

	logic signed [CW-1:0] cx_q [NSTEP+1];
	logic signed [CW-1:0] cy_q [NSTEP+1];
	logic signed [ZW-1:0] cz_q [NSTEP+1];
	logic [15:0]          cm_q [NSTEP+1];
	logic                 c0_q [NSTEP+1];

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q[0] <= px;
			cy_q[0] <= py;
			cz_q[0] <= pz;
			cm_q[0] <= meas;
			c0_q[0] <= (vx == '0) && (vy == '0);
		end
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_q[i] >= 0) begin
					cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] + atan_entry(i);
				end else begin
					cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] - atan_entry(i);
				end
				cm_q[i+1] <= cm_q[i];
				c0_q[i+1] <= c0_q[i];
			end
		end
	end

	logic signed [ZW-1:0] zr;
	logic [15:0]          ang_c;
	logic [15:0]          ang_q;
	logic [15:0]          ad_q [ANG_DLY];

	assign zr = (cz_q[NSTEP] + Z_ROUND) >>> 8;

	always_comb begin
		if (c0_q[NSTEP])
			ang_c = cm_q[NSTEP];
		else if (zr > Z_LIMIT)
			ang_c = Z_LIMIT[15:0];
		else if (zr < -Z_LIMIT)
			ang_c = 16'(-Z_LIMIT);
		else
			ang_c = zr[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q    <= ang_c;
			ad_q[0]  <= ang_q;
			for (int k = 1; k < ANG_DLY; k++)
				ad_q[k] <= ad_q[k-1];
		end
	end

	assign angle = ad_q[ANG_DLY-1];

	// ---------------- magnitude path ----------------
	logic signed [2*VW-1:0] px2, py2;
	logic [SQW-1:0]         sqx_q, sqy_q;

	assign px2 = vx * vx;
	assign py2 = vy * vy;

	logic [SQW-1:0]  rs_rem_q  [MAGW+1];
	logic [MAGW-1:0] rs_root_q [MAGW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_q        <= $unsigned(px2);
			sqy_q        <= $unsigned(py2);
			rs_rem_q[0]  <= sqx_q + sqy_q;
			rs_root_q[0] <= '0;
		end
	end

	// one root bit per stage, msb first
	for (genvar k = 0; k < MAGW; k++) begin : g_root
		localparam int B = MAGW - 1 - k;
		logic [SQW:0] trial;
		assign trial = ((SQW+1)'(rs_root_q[k]) << (B + 1)) + ((SQW+1)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rs_rem_q[k]} >= trial) begin
					rs_rem_q[k+1]  <= rs_rem_q[k] - trial[SQW-1:0];
					rs_root_q[k+1] <= rs_root_q[k] | (MAGW'(1) << B);
				end else begin
					rs_rem_q[k+1]  <= rs_rem_q[k];
					rs_root_q[k+1] <= rs_root_q[k];
				end
			end
		end
	end

	logic [PRW-1:0] mp;
	logic [PRW-1:0] prod_q;
	logic [NW-1:0]  num_q;
	logic [NQW-1:0] nq;

	assign mp = rs_root_q[MAGW] * rpm;
	assign nq = num_q[NQW+DIV_SH-1:DIV_SH];

	// quotient by 16000000: drop the 2^10 factor, then two partial products by the reciprocal
	logic [PPW-1:0] pph_q, ppl_q;
	logic           pp_sat_q;
	logic [PSW-1:0] psum;
	logic [QW-1:0]  quo_q;
	logic           quo_sat_q;

	assign psum = (PSW'(pph_q) << NQH) + PSW'(ppl_q);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q    <= mp;
			num_q     <= NW'(prod_q) + ROUND_HALF;
			pph_q     <= nq[NQW-1:NQH] * RCP_MUL;
			ppl_q     <= nq[NQH-1:0] * RCP_MUL;
			pp_sat_q  <= (num_q >= SAT_LIMIT);
			quo_q     <= psum[RCP_SH+QW-1:RCP_SH];
			quo_sat_q <= pp_sat_q;
		end
	end

	assign speed = quo_sat_q ? SPEED_MAX : quo_q;

endmodule

[hw/rtl/swerve_inverse_kinematics.sv]
// top level of the four-wheel swerve inverse kinematics block: apb registers,
// front-end velocity stages, four sik_wheel pipelines; depends on sik_pkg, sik_wheel
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------------
//  command   in_valid / in_ready  vel_x vel_y yaw_rate chassis_calibrated meas_angle_*
//  result    out_valid/out_ready  angle_fr/fl/rl/rr speed_fr/fl/rl/rr
//  config    apb psel/penable     paddr pwdata prdata pready (always high)
//
// one command per cycle while the result slot is empty or being taken; a result passes v_s1,
// v_s2 and the wheel pipeline, whose depth is set by the bit-per-stage square root (29 stages),
// the product, the rounding add and the two-stage reciprocal multiply that divides by 16000000
// the whole pipeline advances together; when a result waits, every stage holds
// commands blocked by the calibration check are taken and make no result
// arst_n clears valid bits and loads the register reset values; no clearing pass
module swerve_inverse_kinematics import sik_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// command channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] yaw_rate,
	input  logic               chassis_calibrated,
	input  logic signed [15:0] meas_angle_fr,
	input  logic signed [15:0] meas_angle_fl,
	input  logic signed [15:0] meas_angle_rl,
	input  logic signed [15:0] meas_angle_rr,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] angle_fr,
	output logic signed [15:0] angle_fl,
	output logic signed [15:0] angle_rl,
	output logic signed [15:0] angle_rr,
	output logic [19:0]        speed_fr,
	output logic [19:0]        speed_fl,
	output logic [19:0]        speed_rl,
	output logic [19:0]        speed_rr
);

	// ---------------- configuration registers ----------------
	logic        cal_req_q;
	logic [11:0] hl_q;
	logic [11:0] hw_q;
	logic [15:0] rpm_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_req_q <= 1'b0;
			hl_q      <= 12'd200;
			hw_q      <= 12'd200;
			rpm_q     <= 16'd48896;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_CAL_REQ:  cal_req_q <= pwdata[0];
				REG_HALF_LEN: hl_q      <= pwdata[11:0];
				REG_HALF_WID: hw_q      <= pwdata[11:0];
				REG_RPM:      rpm_q     <= pwdata[15:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_CAL_REQ:  prdata = {31'd0, cal_req_q};
			REG_HALF_LEN: prdata = {20'd0, hl_q};
			REG_HALF_WID: prdata = {20'd0, hw_q};
			REG_RPM:      prdata = {16'd0, rpm_q};
		endcase
	end

	// ---------------- flow control ----------------
	// global advance: stages move whenever the output slot is empty or being taken
	logic en;
	logic blocked;
	logic v_s1, v_s2;
	logic vch_q [MAG_LAT];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign blocked  = cal_req_q && !chassis_calibrated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < MAG_LAT; k++)
				vch_q[k] <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid && !blocked;
			v_s2     <= v_s1;
			vch_q[0] <= v_s2;
			for (int k = 1; k < MAG_LAT; k++)
				vch_q[k] <= vch_q[k-1];
		end
	end

	assign out_valid = vch_q[MAG_LAT-1];

	// ---------------- stage 1: shared products ----------------
	// a = 1000*vx, b = 1000*vy in um/s; p = wz*hw, q = wz*hl
	logic signed [25:0] a_mul, b_mul;
	logic signed [28:0] p_mul, q_mul;
	logic signed [25:0] a_s1, b_s1;
	logic signed [28:0] p_s1, q_s1;
	logic [15:0]        meas_s1 [4];

	assign a_mul = vel_x * 26'sd1000;
	assign b_mul = vel_y * 26'sd1000;
	assign p_mul = yaw_rate * $signed({1'b0, hw_q});
	assign q_mul = yaw_rate * $signed({1'b0, hl_q});

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1       <= a_mul;
			b_s1       <= b_mul;
			p_s1       <= p_mul;
			q_s1       <= q_mul;
			meas_s1[0] <= meas_angle_fr;
			meas_s1[1] <= meas_angle_fl;
			meas_s1[2] <= meas_angle_rl;
			meas_s1[3] <= meas_angle_rr;
		end
	end

	// ---------------- stage 2: per-wheel velocity ----------------
	// fr (+hl,-hw), fl (+hl,+hw), rl (-hl,+hw), rr (-hl,-hw)
	wvel_t       ae, be, pe, qe;
	wvel_t       wvx_s2 [4];
	wvel_t       wvy_s2 [4];
	logic [15:0] meas_s2 [4];

	assign ae = VW'(a_s1);
	assign be = VW'(b_s1);
	assign pe = p_s1;
	assign qe = q_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wvx_s2[0] <= ae + pe;
			wvy_s2[0] <= be + qe;
			wvx_s2[1] <= ae - pe;
			wvy_s2[1] <= be + qe;
			wvx_s2[2] <= ae - pe;
			wvy_s2[2] <= be - qe;
			wvx_s2[3] <= ae + pe;
			wvy_s2[3] <= be - qe;
			for (int w = 0; w < 4; w++)
				meas_s2[w] <= meas_s1[w];
		end
	end

	// ---------------- wheel pipelines ----------------
	logic [15:0]   ang_w [4];
	logic [QW-1:0] spd_w [4];

	for (genvar w = 0; w < 4; w++) begin : g_wheel
		sik_wheel u_wheel (
			.clk   (clk),
			.en    (en),
			.vx    (wvx_s2[w]),
			.vy    (wvy_s2[w]),
			.meas  (meas_s2[w]),
			.rpm   (rpm_q),
			.angle (ang_w[w]),
			.speed (spd_w[w])
		);
	end

	assign angle_fr = ang_w[0];
	assign angle_fl = ang_w[1];
	assign angle_rl = ang_w[2];
	assign angle_rr = ang_w[3];
	assign speed_fr = spd_w[0];
	assign speed_fl = spd_w[1];
	assign speed_rl = spd_w[2];
	assign speed_rr = spd_w[3];

	// ---------------- checks ----------------
	a_block_drops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && blocked |=> !v_s1)
		else $error("blocked command entered the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> (v_s1 == $past(v_s1)) && (v_s2 == $past(v_s2)))
		else $error("front stages moved during a stall");

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && v_s2 |=> vch_q[0])
		else $error("valid bit lost between front end and wheel pipelines");

endmodule
